// File: rtl/hsl_to_rgb_pixel_assert.svh
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel_assert.svh
// Assertion macros for the HSL to RGB pixel converter. In synthesis builds
// the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_PIXEL_ASSERT_SVH
`define HSL_TO_RGB_PIXEL_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of aclk, switched off while aresetn is low.
`define HSL_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("hsl_to_rgb_pixel: assertion failed");
// Checked on every rising edge of aclk, reset included.
`define HSL_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("hsl_to_rgb_pixel: reset assertion failed");
`else
`define HSL_ASSERT(label, prop)
`define HSL_ASSERT_RST(label, prop)
`endif

`endif

// File: rtl/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared widths, sector codes and payload types of the HSL to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl2rgb_pkg;

    localparam int HUE_W        = 11;
    localparam int CH_W         = 8;
    localparam int NUM_W        = 18;
    localparam int FRONT_STAGES = 4;
    localparam int DIV_STAGES   = 2;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

    // Hue sectors of 60 degrees each; codes six and seven share the last one.
    localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;

    // Per-channel numerators; each channel is numerator / 510.
    typedef struct packed {
        logic [NUM_W-1:0] red;
        logic [NUM_W-1:0] green;
        logic [NUM_W-1:0] blue;
    } chan_num_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

endpackage

`default_nettype wire

// File: rtl/hsl2rgb_front.sv
// ----------------------------------------------------------------------------
// hsl2rgb_front
// First four pipeline stages: chroma factor, a*s product, the X product and
// the sector placement into three channel numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_front
    import hsl2rgb_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic [FRONT_STAGES-1:0] en,
    input  wire logic [HUE_W-1:0]        hue,
    input  wire logic [CH_W-1:0]         saturation,
    input  wire logic [CH_W-1:0]         lightness,
    output chan_num_t                    num
);

    // Stage 0: a = 255 - |2l - 255| and the sector fraction t.
    logic [8:0] twol;
    logic [7:0] lum_dev;
    logic [7:0] a_next;
    logic [8:0] t_next;
    logic [7:0] a0_reg, s0_reg, l0_reg;
    logic [8:0] t0_reg;
    logic [2:0] sec0_reg;

    always_comb begin
        twol    = {lightness, 1'b0};
        lum_dev = (twol >= 9'd255) ? 8'(twol - 9'd255) : 8'(9'd255 - twol);
        a_next  = 8'd255 - lum_dev;
        t_next  = hue[8] ? (9'd256 - {1'b0, hue[7:0]}) : {1'b0, hue[7:0]};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a0_reg   <= a_next;
            s0_reg   <= saturation;
            l0_reg   <= lightness;
            t0_reg   <= t_next;
            sec0_reg <= hue[10:8];
        end
    end

    // Stage 1: as = a*s, and 510*l by shift and subtract.
    logic [15:0] as1_next;
    logic [16:0] l510_next;
    logic [15:0] as1_reg;
    logic [16:0] l510_1_reg;
    logic [8:0]  t1_reg;
    logic [2:0]  sec1_reg;

    assign as1_next  = 16'(a0_reg) * 16'(s0_reg);
    assign l510_next = {l0_reg, 9'b0} - 17'({l0_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            as1_reg    <= as1_next;
            l510_1_reg <= l510_next;
            t1_reg     <= t0_reg;
            sec1_reg   <= sec0_reg;
        end
    end

    // Stage 2: as*t for X, plus the chroma and zero numerators.
    logic [24:0]      ast2_next;
    logic [NUM_W-1:0] basec_next, basez_next;
    logic [24:0]      ast2_reg;
    logic [NUM_W-1:0] basec2_reg, basez2_reg;
    logic [2:0]       sec2_reg;

    assign ast2_next  = 25'(as1_reg) * 25'(t1_reg);
    assign basec_next = NUM_W'(as1_reg) + NUM_W'(l510_1_reg);
    assign basez_next = NUM_W'(l510_1_reg) - NUM_W'(as1_reg);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            ast2_reg   <= ast2_next;
            basec2_reg <= basec_next;
            basez2_reg <= basez_next;
            sec2_reg   <= sec1_reg;
        end
    end

    // Stage 3: X numerator and placement by sector.
    logic [NUM_W-1:0] basex;
    chan_num_t        num_next;
    chan_num_t        num_reg;

    always_comb begin
        basex = ast2_reg[24:7] + basez2_reg;
        case (sec2_reg)
            SEC_RED_YELLOW: begin
                num_next = '{red: basec2_reg, green: basex, blue: basez2_reg};
            end
            SEC_YELLOW_GREEN: begin
                num_next = '{red: basex, green: basec2_reg, blue: basez2_reg};
            end
            SEC_GREEN_CYAN: begin
                num_next = '{red: basez2_reg, green: basec2_reg, blue: basex};
            end
            SEC_CYAN_BLUE: begin
                num_next = '{red: basez2_reg, green: basex, blue: basec2_reg};
            end
            SEC_BLUE_MAGENTA: begin
                num_next = '{red: basex, green: basez2_reg, blue: basec2_reg};
            end
            default: begin
                num_next = '{red: basec2_reg, green: basez2_reg, blue: basex};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            num_reg <= num_next;
        end
    end

    assign num = num_reg;

endmodule

`default_nettype wire

// File: rtl/hsl2rgb_div510.sv
// ----------------------------------------------------------------------------
// hsl2rgb_div510
// Two-stage divide by 510: a reciprocal estimate by 257/65536 on n/2, then
// one compare and subtract that corrects the estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_div510
    import hsl2rgb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic [DIV_STAGES-1:0] en,
    input  wire logic [NUM_W-1:0]      num,
    output logic [CH_W-1:0]            quo
);

    // The estimate is the true quotient or one below it.
    logic [NUM_W-2:0] y_next;
    logic [25:0]      prod;
    logic [NUM_W-2:0] y_reg;
    logic [9:0]       q0_reg;

    assign y_next = num[NUM_W-1:1];
    assign prod   = 26'({y_next, 8'b0}) + 26'(y_next);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            y_reg  <= y_next;
            q0_reg <= prod[25:16];
        end
    end

    logic [NUM_W-1:0] q0x255;
    logic [NUM_W-1:0] rem;
    logic [9:0]       q_next;
    logic [CH_W-1:0]  quo_reg;

    always_comb begin
        q0x255 = {q0_reg, 8'b0} - NUM_W'(q0_reg);
        rem    = NUM_W'(y_reg) - q0x255;
        q_next = (rem >= NUM_W'(255)) ? (q0_reg + 10'd1) : q0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            quo_reg <= q_next[CH_W-1:0];
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// File: rtl/hsl2rgb_skid.sv
// ----------------------------------------------------------------------------
// hsl2rgb_skid
// Output register with a one-word skid stage, so that the ready toward the
// pipeline comes straight from a flip-flop.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_skid
    import hsl2rgb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire rgb_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output rgb_t      out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    rgb_t out_data_reg, out_data_next;
    rgb_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/hsl_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_pixel
// Converts one HSL pixel word to 8-bit RGB in exact fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                     Direction
//   input     s_valid s_ready s_hue s_saturation        in
//             s_lightness
//   result    m_valid m_ready m_red m_green m_blue      out
//
// The block takes one word per clock while the output is not stalled, and
// passes it through six pipeline stages (chroma factor, two multiplies,
// placement, two-stage divide by 510) and then the output register. The
// chain of stage enables lets bubbles close up.
// Reset clears only the valid bits; data registers keep whatever they hold.
// On a stall every stage holds its word; the skid stage catches the one word
// in flight, so s_ready is never a combinational function of m_ready.
//
// Math: with a = 255 - |2l - 255| and t the fraction within the sector
// (mirrored in odd sectors), every channel is floor(n / 510), where n is
// a*s + 510*l for the chroma channel, 510*l - a*s for the zero channel and
// floor(a*s*t / 128) + 510*l - a*s for the X channel.
//
`default_nettype none

module hsl_to_rgb_pixel
    import hsl2rgb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [HUE_W-1:0] s_hue,
    input  wire logic [CH_W-1:0]  s_saturation,
    input  wire logic [CH_W-1:0]  s_lightness,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [CH_W-1:0]       m_red,
    output logic [CH_W-1:0]       m_green,
    output logic [CH_W-1:0]       m_blue
);

`include "hsl_to_rgb_pixel_assert.svh"

    // One valid bit per stage travels with the word in that stage.
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] valid_in;
    logic [NUM_STAGES-1:0] en;
    logic                  skid_ready;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || skid_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign valid_in   = {valid_reg[NUM_STAGES-2:0], s_valid};
    assign valid_next = (en & valid_in) | (~en & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en[0];

    // Datapath.
    chan_num_t       num;
    logic [CH_W-1:0] pix_red, pix_green, pix_blue;
    rgb_t            pix;
    rgb_t            out_pix;

    hsl2rgb_front u_front (
        .aclk       (aclk),
        .en         (en[FRONT_STAGES-1:0]),
        .hue        (s_hue),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .num        (num)
    );

    hsl2rgb_div510 u_div_red (
        .aclk (aclk),
        .en   (en[NUM_STAGES-1:FRONT_STAGES]),
        .num  (num.red),
        .quo  (pix_red)
    );

    hsl2rgb_div510 u_div_green (
        .aclk (aclk),
        .en   (en[NUM_STAGES-1:FRONT_STAGES]),
        .num  (num.green),
        .quo  (pix_green)
    );

    hsl2rgb_div510 u_div_blue (
        .aclk (aclk),
        .en   (en[NUM_STAGES-1:FRONT_STAGES]),
        .num  (num.blue),
        .quo  (pix_blue)
    );

    assign pix = '{red: pix_red, green: pix_green, blue: pix_blue};

    // Output register and skid stage.
    hsl2rgb_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_reg[NUM_STAGES-1]),
        .in_ready  (skid_ready),
        .in_data   (pix),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_pix)
    );

    assign m_red   = out_pix.red;
    assign m_green = out_pix.green;
    assign m_blue  = out_pix.blue;

    // The input side can only stall when every stage holds a word and the
    // skid stage is full.
    `HSL_ASSERT(a_stall_only_when_full, !s_ready |-> ((&valid_reg) && !skid_ready))
    // A word sits in the skid stage only behind a word shown at the output.
    `HSL_ASSERT(a_skid_behind_output, !skid_ready |-> m_valid)
    // Reset empties the pipeline and the output.
    `HSL_ASSERT_RST(a_reset_empties, !aresetn |=> (!m_valid && (valid_reg == '0)))

endmodule

`default_nettype wire

// File: tb/sv/tb_hsl_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_pixel
// Self-checking bench for the HSL to RGB pixel converter. A queue of HSL
// words, directed corner cases first and then random pixels, feeds a clocked
// driver. Every word that the block accepts is converted by an exact integer
// model of the conversion. A clocked monitor compares each RGB word leaving
// the block, channel by channel, against the oldest prediction. Both sides
// pause at random so that back-pressure reaches every pipeline stage.
// ----------------------------------------------------------------------------

module tb_hsl_to_rgb_pixel;
    import hsl2rgb_pkg::*;

    // Common denominator 2*255*255*256 of chroma, X and m in the exact model.
    localparam longint unsigned PIX_DEN    = 64'd33292800;
    localparam int              RAND_WORDS = 1600;
    localparam int              DRAIN_WAIT = 16;
    localparam int              IDLE_LIMIT = 500;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  lit;
    } hsl_word_t;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [HUE_W-1:0] s_hue        = '0;
    logic [CH_W-1:0]  s_saturation = '0;
    logic [CH_W-1:0]  s_lightness  = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [CH_W-1:0]  m_red;
    logic [CH_W-1:0]  m_green;
    logic [CH_W-1:0]  m_blue;

    hsl_word_t pixel_queue[$];   // HSL words still to be sent
    rgb_t      expected_rgb[$];  // predicted RGB words, oldest first

    int send_gap      = 0;
    int recv_stall    = 0;
    int idle_cycles   = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int directed_cnt  = 0;
    int mismatches    = 0;

    hsl_to_rgb_pixel i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // One channel: floor(255 * (component + m) / D), clipped and cut to 8 bits.
    // Both terms are already scaled by the common denominator D.
    function automatic logic [CH_W-1:0] scale_channel(longint unsigned comp,
                                                      longint unsigned offs);
        longint unsigned v;
        v = (64'd255 * (comp + offs)) / PIX_DEN;
        if (v > 64'd255) begin
            v = 64'd255;
        end
        return v[CH_W-1:0];
    endfunction

    // Exact conversion of one HSL word. The hue's upper three bits are the
    // 60-degree sector and the low byte the position inside it; odd sectors
    // mirror that position, so X falls as the hue climbs through them.
    function automatic rgb_t hsl_to_rgb(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                        logic [CH_W-1:0] lit);
        logic [2:0]      sector;
        longint unsigned frac, twol, lum_dev, a, as, t, cs, xs, ms;
        longint unsigned rn, gn, bn;
        rgb_t            px;
        sector  = hue[HUE_W-1:8];
        frac    = longint'(hue[7:0]);
        twol    = 2 * longint'(lit);
        lum_dev = (twol >= 255) ? (twol - 255) : (255 - twol);
        a       = 255 - lum_dev;
        as      = a * longint'(sat);
        t       = sector[0] ? (256 - frac) : frac;
        cs      = 512 * as;
        xs      = 2 * as * t;
        ms      = 512 * 255 * longint'(lit) - 256 * as;
        case (sector)
            SEC_RED_YELLOW: begin
                rn = cs; gn = xs; bn = 0;
            end
            SEC_YELLOW_GREEN: begin
                rn = xs; gn = cs; bn = 0;
            end
            SEC_GREEN_CYAN: begin
                rn = 0; gn = cs; bn = xs;
            end
            SEC_CYAN_BLUE: begin
                rn = 0; gn = xs; bn = cs;
            end
            SEC_BLUE_MAGENTA: begin
                rn = xs; gn = 0; bn = cs;
            end
            // Magenta to red, the full circle and the codes past it all
            // share the last placement.
            default: begin
                rn = cs; gn = 0; bn = xs;
            end
        endcase
        px.red   = scale_channel(rn, ms);
        px.green = scale_channel(gn, ms);
        px.blue  = scale_channel(bn, ms);
        return px;
    endfunction

    // Wait drawn per word. Every fourth stretch of 150 words runs without
    // any pause so that the block also sees long back-to-back bursts.
    function automatic int draw_wait(int n);
        if ((n / 150) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [CH_W-1:0] extreme_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    task automatic add_word(int hue, int sat, int lit);
        hsl_word_t w;
        w.hue = hue[HUE_W-1:0];
        w.sat = sat[CH_W-1:0];
        w.lit = lit[CH_W-1:0];
        pixel_queue.push_back(w);
    endtask

    // Driver. A word is taken off the queue only when the channel is free or
    // its current word is being accepted at this edge. The prediction is made
    // from the payload that the block actually accepted.
    always @(posedge aclk) begin
        hsl_word_t w;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_rgb.push_back(hsl_to_rgb(s_hue, s_saturation, s_lightness));
                words_sent++;
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                w            = pixel_queue.pop_front();
                s_hue        <= w.hue;
                s_saturation <= w.sat;
                s_lightness  <= w.lit;
                s_valid      <= 1'b1;
                send_gap     <= draw_wait(words_sent);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted RGB word is checked against the oldest
    // prediction; after each one the receiver draws how long it stalls.
    always @(posedge aclk) begin
        rgb_t want;
        int   n;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_rgb.size() == 0) begin
                $display("%0t: unexpected RGB word %0d %0d %0d with nothing predicted",
                         $time, m_red, m_green, m_blue);
                mismatches++;
            end else begin
                want = expected_rgb.pop_front();
                if (m_red !== want.red) begin
                    $display("%0t: red mismatch, expected %0d, got %0d",
                             $time, want.red, m_red);
                    mismatches++;
                end
                if (m_green !== want.green) begin
                    $display("%0t: green mismatch, expected %0d, got %0d",
                             $time, want.green, m_green);
                    mismatches++;
                end
                if (m_blue !== want.blue) begin
                    $display("%0t: blue mismatch, expected %0d, got %0d",
                             $time, want.blue, m_blue);
                    mismatches++;
                end
            end
            words_checked++;
            n = draw_wait(words_checked);
            if (n == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready    <= 1'b0;
                recv_stall <= n - 1;
            end
        end else if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: counts edges with work outstanding but no word moving on
    // either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (s_valid || pixel_queue.size() != 0 || expected_rgb.size() != 0) begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int k;
        int h;
        int sat;
        int lit;

        // Directed words: sector boundaries of every hue sector, the full
        // circle, hue codes past 360 degrees, and the extremes of saturation
        // and lightness (black, white, grey, one step off black and white).
        add_word(0, 255, 128);
        add_word(255, 255, 128);
        add_word(256, 255, 127);
        add_word(511, 255, 128);
        add_word(512, 200, 100);
        add_word(767, 255, 128);
        add_word(768, 128, 64);
        add_word(1023, 255, 200);
        add_word(1024, 255, 128);
        add_word(1279, 77, 180);
        add_word(1280, 255, 128);
        add_word(1535, 255, 128);
        add_word(1536, 255, 128);
        add_word(1537, 255, 128);
        add_word(1792, 200, 128);
        add_word(2047, 255, 128);
        add_word(1536, 0, 0);
        add_word(1536, 255, 255);
        add_word(700, 0, 255);
        add_word(300, 255, 0);
        add_word(900, 0, 128);
        add_word(1200, 170, 127);
        add_word(100, 1, 1);
        add_word(1400, 254, 254);
        directed_cnt = pixel_queue.size();

        // Random pixels. Most hues are legal, some sit on sector edges and a
        // few lie past the full circle.
        for (k = 0; k < RAND_WORDS; k++) begin
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 7) * 256 + ($urandom_range(0, 1) ? 255 : 0);
                1:       h = $urandom_range(1537, 2047);
                default: h = $urandom_range(0, 1536);
            endcase
            sat = ($urandom_range(0, 6) == 0) ? extreme_level() : $urandom_range(0, 255);
            lit = ($urandom_range(0, 6) == 0) ? extreme_level() : $urandom_range(0, 255);
            add_word(h, sat, lit);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pixel_queue.size() != 0 || s_valid || expected_rgb.size() != 0) begin
            @(posedge aclk);
        end
        // Give a stray extra word time to surface before judging the run.
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Run summary: %0d HSL words sent (%0d directed, %0d random), %0d RGB words checked.",
                 words_sent, directed_cnt, words_sent - directed_cnt, words_checked);
        $display("Hues spanned all eight sector codes incl. 360 degrees; %0d channel errors.",
                 mismatches);
        if (mismatches == 0 && words_checked == words_sent) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_front.sv
rtl/hsl2rgb_div510.sv
rtl/hsl2rgb_skid.sv
rtl/hsl_to_rgb_pixel.sv
tb/sv/tb_hsl_to_rgb_pixel.sv
